>>> design/crld_pkg.sv
// Package for the cluster run list decoder.
// Phase codes, result beat type and field size limit; no dependencies.
package crld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam logic [3:0] MAX_NIB = 4'(MAX_FIELD_BYTES);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_OFFSET  = 4'b0100,
        PH_ABANDON = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [63:0] run_length;
        logic [63:0] start_cluster;
        logic        end_of_list;
        logic        bad_header;
    } t_result;

endpackage

>>> design/crld_parser.sv
// Run list byte parser: header decode, field gathering, delta add.
// Depends on crld_pkg.
module crld_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_data_byte,
    input  logic             i_list_start,
    output logic             o_res_valid,
    output crld_pkg::t_result o_res
);
    import crld_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_len_left, n_len_left;
    logic [3:0]  r_off_left, n_off_left;
    logic [3:0]  r_off_size, n_off_size;
    logic [2:0]  r_pos, n_pos;
    logic [63:0] r_len_acc, n_len_acc;
    logic [63:0] r_off_acc, n_off_acc;
    logic [63:0] r_prev, n_prev;

    t_phase      ph;
    logic [63:0] base;
    logic [63:0] placed;
    logic [63:0] delta;
    logic [3:0]  lnib, onib;
    logic        finish;

    assign lnib   = i_data_byte[3:0];
    assign onib   = i_data_byte[7:4];
    assign placed = 64'(i_data_byte) << {r_pos, 3'b000};

    always_comb begin
        ph          = i_list_start ? PH_HEADER : r_phase;
        base        = i_list_start ? '0 : r_prev;
        n_phase     = ph;
        n_len_left  = r_len_left;
        n_off_left  = r_off_left;
        n_off_size  = r_off_size;
        n_pos       = r_pos;
        n_len_acc   = r_len_acc;
        n_off_acc   = r_off_acc;
        n_prev      = base;
        finish      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (ph)
            PH_HEADER: begin
                if (i_data_byte == 8'd0) begin
                    n_prev            = '0;
                    o_res_valid       = 1'b1;
                    o_res.end_of_list = 1'b1;
                end else if (lnib > MAX_NIB || onib > MAX_NIB) begin
                    n_phase          = PH_ABANDON;
                    o_res_valid      = 1'b1;
                    o_res.bad_header = 1'b1;
                end else begin
                    n_len_left = lnib;
                    n_off_left = onib;
                    n_off_size = onib;
                    n_pos      = '0;
                    n_len_acc  = '0;
                    n_off_acc  = '0;
                    n_phase    = (lnib != 4'd0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                n_len_acc  = r_len_acc | placed;
                n_pos      = r_pos + 3'd1;
                n_len_left = r_len_left - 4'd1;
                if (n_len_left == 4'd0) begin
                    n_pos = '0;
                    if (r_off_left == 4'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                n_off_acc  = r_off_acc | placed;
                n_pos      = r_pos + 3'd1;
                n_off_left = r_off_left - 4'd1;
                if (n_off_left == 4'd0) begin
                    finish = 1'b1;
                end
            end
            PH_ABANDON: begin
            end
            default: begin
            end
        endcase

        // sign-extend the offset delta for field sizes below eight bytes
        delta = n_off_acc;
        for (int k = 1; k < 8; k++) begin
            if (n_off_size == 4'(k) && delta[8*k-1]) begin
                delta = delta | ({64{1'b1}} << (8 * k));
            end
        end

        if (finish) begin
            n_phase = PH_HEADER;
            if (delta != 64'd0) begin
                n_prev              = base + delta;
                o_res_valid         = 1'b1;
                o_res.run_length    = n_len_acc;
                o_res.start_cluster = base + delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_len_left <= '0;
            r_off_left <= '0;
            r_off_size <= '0;
            r_pos      <= '0;
            r_prev     <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_left <= n_off_left;
            r_off_size <= n_off_size;
            r_pos      <= n_pos;
            r_prev     <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_len_acc <= n_len_acc;
            r_off_acc <= n_off_acc;
        end
    end

    a_bad_abandons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && o_res.bad_header |=> r_phase == PH_ABANDON)
        else $error("bad header did not abandon the list");

    a_offset_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_OFFSET |-> r_off_left != 4'd0)
        else $error("offset phase with no offset bytes left");

    a_counts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_left <= MAX_NIB && r_off_left <= MAX_NIB && r_off_size <= MAX_NIB)
        else $error("field byte count out of range");

endmodule

>>> design/crld_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on crld_pkg.
module crld_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  crld_pkg::t_result i_res,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output crld_pkg::t_result o_res,
    output logic             o_in_stall
);
    import crld_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_in_stall  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= r_skid_valid && i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held with empty output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !out_free |=> r_skid_valid && $stable(r_skid))
        else $error("skid beat overwritten while stalled");

endmodule

>>> design/cluster_run_list_decoder_unit.sv
// Cluster run list decoder, top level.
// Takes run list bytes one beat at a time and returns decoded runs.
// Depends on crld_pkg, crld_parser and crld_out_buf.
//
// Input channel: i_data_byte and i_list_start, taken when i_in_valid is
// high and o_in_stall is low. Set i_list_start on the first header of a
// list; it restarts decoding in any phase and clears the running base.
// Output channel: one beat per emitted run (length and absolute start),
// per zero terminator (end_of_list) or per bad header (bad_header, after
// which bytes are dropped until the next list start). Sparse runs and
// field bytes give no beat. A beat is taken when o_out_valid is high and
// i_out_stall is low.
// Throughput is one byte per cycle while o_in_stall is low. A result is
// registered in the output register, or in the skid register while the
// output is stalled; the header decode, offset sign extension and 64-bit
// start add are combinational ahead of these registers.
// A stalled receiver fills the output register, then the skid register;
// o_in_stall rises only while the skid register is occupied.
// Reset (i_rst_n low, synchronous) returns to expecting a header with a
// zero base and empties both result registers.
module cluster_run_list_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_list_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_run_length,
    output logic [63:0] o_start_cluster,
    output logic        o_end_of_list,
    output logic        o_bad_header
);
    import crld_pkg::*;

    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign fire = i_in_valid && !o_in_stall;

    crld_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_data_byte  (i_data_byte),
        .i_list_start (i_list_start),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    crld_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid && fire),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res),
        .o_in_stall  (o_in_stall)
    );

    assign o_run_length    = out_res.run_length;
    assign o_start_cluster = out_res.start_cluster;
    assign o_end_of_list   = out_res.end_of_list;
    assign o_bad_header    = out_res.bad_header;

endmodule
